// File: sv/assert_macros.svh
// Assertion macros shared by the RTL of the frequency model.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/acfm_pkg.sv
// Shared constants, opcodes, FSM state type and memory request structs
// for the arithmetic coder frequency model. No dependencies.
`default_nettype none

package acfm_pkg;

  localparam int SYMBOLS   = 256;
  localparam int FREQ_BITS = 24;
  localparam int CNT_W     = 32;
  localparam int OP_W      = 3;
  localparam int SYM_W     = $clog2(SYMBOLS);
  localparam int IDX_W     = SYM_W + 1;

  localparam logic [IDX_W-1:0]     SYM_CNT  = IDX_W'(SYMBOLS);
  localparam logic [SYM_W-1:0]     SYM_LAST = SYM_W'(SYMBOLS - 1);
  localparam logic [FREQ_BITS-1:0] FREQ_MAX = {FREQ_BITS{1'b1}};

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_CLEAR  = 3'd0;
  localparam op_t OP_TRAIN  = 3'd1;
  localparam op_t OP_BUILD  = 3'd2;
  localparam op_t OP_QUERY  = 3'd3;
  localparam op_t OP_DECODE = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRAIN,
    S_BUILD,
    S_BUILD_END,
    S_PROBE,
    S_CMP,
    S_FETCH,
    S_RESULT
  } state_t;

  // Frequency store access for one cycle
  typedef struct packed {
    logic                 clear;
    logic [SYM_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [SYM_W-1:0]     wr_addr;
    logic [FREQ_BITS-1:0] wr_data;
  } freq_req_t;

  // Cumulative store access for one cycle; entry j holds cum[j+1]
  typedef struct packed {
    logic [SYM_W-1:0] rd_addr_a;
    logic [SYM_W-1:0] rd_addr_b;
    logic             wr_en;
    logic [SYM_W-1:0] wr_addr;
    logic [CNT_W-1:0] wr_data;
    logic             built_set;
  } cum_req_t;

endpackage

`default_nettype wire

// File: sv/acfm_freq_store.sv
// Frequency memory: one write port, one registered read port, with a
// valid bit per entry so that unwritten or cleared entries read as 1. Uses acfm_pkg.
`default_nettype none

module acfm_freq_store
  import acfm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire freq_req_t            req,
  output      logic [FREQ_BITS-1:0] rd_freq
);

  logic [FREQ_BITS-1:0] mem [SYMBOLS];
  logic [SYMBOLS-1:0]   valid;
  logic [FREQ_BITS-1:0] rd_data;
  logic                 rd_valid;

  // Write and read the array
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data  <= mem[req.rd_addr];
    rd_valid <= valid[req.rd_addr];
  end

  // Drop all valid bits on reset or clear, mark entries as written
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_freq = rd_valid ? rd_data : FREQ_BITS'(1);

endmodule

`default_nettype wire

// File: sv/acfm_cum_store.sv
// Cumulative count memory: entry j holds cum[j+1]; two registered read
// ports, one write port. Reads give j+1 until the first build. Uses acfm_pkg.
`default_nettype none

module acfm_cum_store
  import acfm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cum_req_t         req,
  output      logic [CNT_W-1:0] rd_a,
  output      logic [CNT_W-1:0] rd_b
);

  logic [CNT_W-1:0] mem [SYMBOLS];
  logic [CNT_W-1:0] data_a;
  logic [CNT_W-1:0] data_b;
  logic [SYM_W-1:0] addr_a;
  logic [SYM_W-1:0] addr_b;
  logic             built;

  // Write and read the array
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    data_a <= mem[req.rd_addr_a];
    data_b <= mem[req.rd_addr_b];
    addr_a <= req.rd_addr_a;
    addr_b <= req.rd_addr_b;
  end

  // Hold the reset image until a build has written every entry
  always_ff @(posedge clk) begin
    if (rst) begin
      built <= 1'b0;
    end else if (req.built_set) begin
      built <= 1'b1;
    end
  end

  assign rd_a = built ? data_a : CNT_W'(addr_a) + CNT_W'(1);
  assign rd_b = built ? data_b : CNT_W'(addr_b) + CNT_W'(1);

endmodule

`default_nettype wire

// File: sv/arith_coder_frequency_model_unit.sv
// Arithmetic coder frequency model: command FSM over a frequency memory and a
// cumulative memory. Clear and unused opcodes finish straight from idle, train
// writes one frequency, query fetches one cumulative pair, decode binary-searches
// the cumulative memory and then fetches, build sweeps all SYMBOLS entries with one memory read per cycle.
// One command at a time; busy is high until the result word is shown.
// Reset: frequencies read as 1, cumulative entry j as j+1, total SYMBOLS.
`default_nettype none
`include "assert_macros.svh"

module arith_coder_frequency_model_unit
  import acfm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [OP_W-1:0]  opcode,
  input  wire logic [SYM_W-1:0] symbol_in,
  input  wire logic [CNT_W-1:0] target_count,
  output      logic             busy,
  output      logic             done,
  output      logic [CNT_W-1:0] cum_low,
  output      logic [CNT_W-1:0] cum_high,
  output      logic [CNT_W-1:0] total_count,
  output      logic [SYM_W-1:0] symbol_out,
  output      logic             status
);

  state_t state, state_next;

  freq_req_t            freq_req;
  cum_req_t             cum_req;
  logic [FREQ_BITS-1:0] rd_freq;
  logic [CNT_W-1:0]     cum_a;
  logic [CNT_W-1:0]     cum_b;

  logic [CNT_W-1:0]     model_total;
  logic [CNT_W-1:0]     key;
  logic [SYM_W-1:0]     sym_q;
  logic                 train_ok;
  logic [IDX_W-1:0]     lo;
  logic [IDX_W-1:0]     hi;
  logic [SYM_W-1:0]     mid;
  logic [SYM_W-1:0]     symo;
  logic                 st;
  logic                 low_zero;
  logic [SYM_W-1:0]     bidx;
  logic                 bld_pend;
  logic [SYM_W-1:0]     bld_addr;
  logic [CNT_W-1:0]     acc;

  logic [CNT_W:0]       acc_sum;
  logic [CNT_W-1:0]     acc_sat;
  logic [FREQ_BITS:0]   f_sum;
  logic [FREQ_BITS-1:0] f_sat;
  logic [IDX_W:0]       mid_sum;
  logic [SYM_W-1:0]     mid_c;
  logic                 search_more;
  logic                 over;
  logic [SYM_W-1:0]     sym_clamp;

  acfm_freq_store u_freq (
    .clk     (clk),
    .rst     (rst),
    .req     (freq_req),
    .rd_freq (rd_freq)
  );

  acfm_cum_store u_cum (
    .clk  (clk),
    .rst  (rst),
    .req  (cum_req),
    .rd_a (cum_a),
    .rd_b (cum_b)
  );

  // Saturating adders, search midpoint and range checks
  always_comb begin
    acc_sum     = {1'b0, acc} + (CNT_W+1)'(rd_freq);
    acc_sat     = acc_sum[CNT_W] ? {CNT_W{1'b1}} : acc_sum[CNT_W-1:0];
    f_sum       = {1'b0, rd_freq} + (FREQ_BITS+1)'(2);
    f_sat       = f_sum[FREQ_BITS] ? FREQ_MAX : f_sum[FREQ_BITS-1:0];
    mid_sum     = (IDX_W+1)'(lo) + (IDX_W+1)'(hi);
    mid_c       = mid_sum[SYM_W:1];
    search_more = ((IDX_W+1)'(lo) + (IDX_W+1)'(1)) < (IDX_W+1)'(hi);
    over        = target_count >= model_total;
    sym_clamp   = ({1'b0, symbol_in} >= SYM_CNT) ? SYM_LAST : symbol_in;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          priority case (opcode)
            OP_TRAIN:  state_next = S_TRAIN;
            OP_BUILD:  state_next = S_BUILD;
            OP_QUERY:  state_next = S_FETCH;
            OP_DECODE: state_next = over ? S_FETCH : S_PROBE;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_TRAIN:     state_next = S_IDLE;
      S_BUILD:     state_next = (bidx == SYM_LAST) ? S_BUILD_END : S_BUILD;
      S_BUILD_END: state_next = S_IDLE;
      S_PROBE:     state_next = search_more ? S_CMP : S_FETCH;
      S_CMP:       state_next = (key != cum_a) ? S_PROBE : S_FETCH;
      S_FETCH:     state_next = S_RESULT;
      S_RESULT:    state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Memory requests and busy
  always_comb begin
    busy              = (state != S_IDLE);
    freq_req.clear    = (state == S_IDLE) && start && (opcode == OP_CLEAR);
    freq_req.rd_addr  = (state == S_BUILD) ? bidx : symbol_in;
    freq_req.wr_en    = (state == S_TRAIN) && train_ok;
    freq_req.wr_addr  = sym_q;
    freq_req.wr_data  = f_sat;
    cum_req.rd_addr_a = (state == S_PROBE) ? mid_c - SYM_W'(1) : symo - SYM_W'(1);
    cum_req.rd_addr_b = symo;
    cum_req.wr_en     = bld_pend;
    cum_req.wr_addr   = bld_addr;
    cum_req.wr_data   = acc_sat;
    cum_req.built_set = (state == S_BUILD_END);
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers: strobe, build pipeline flag, total
  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      bld_pend    <= 1'b0;
      model_total <= CNT_W'(SYMBOLS);
    end else begin
      done     <= 1'b0;
      bld_pend <= (state == S_BUILD);
      unique case (state)
        S_IDLE: begin
          if (start && (opcode != OP_TRAIN) && (opcode != OP_BUILD) &&
              (opcode != OP_QUERY) && (opcode != OP_DECODE)) begin
            done <= 1'b1;
          end
        end
        S_TRAIN:     done <= 1'b1;
        S_BUILD_END: begin
          done        <= 1'b1;
          model_total <= acc_sat;
        end
        S_RESULT:    done <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // Datapath: search bounds, build sweep, result word
  always_ff @(posedge clk) begin
    if (bld_pend) begin
      acc <= acc_sat;
    end
    unique case (state)
      S_IDLE: begin
        key      <= target_count;
        sym_q    <= symbol_in;
        train_ok <= ({1'b0, symbol_in} < SYM_CNT);
        lo       <= '0;
        hi       <= SYM_CNT;
        bidx     <= '0;
        acc      <= '0;
        st       <= (opcode == OP_DECODE) && over;
        symo     <= (opcode == OP_DECODE) ? SYM_LAST : sym_clamp;
        cum_low     <= '0;
        cum_high    <= '0;
        total_count <= model_total;
        symbol_out  <= '0;
        status      <= 1'b0;
      end
      S_TRAIN: begin
        cum_low     <= '0;
        cum_high    <= '0;
        total_count <= model_total;
        symbol_out  <= '0;
        status      <= 1'b0;
      end
      S_BUILD: begin
        bidx     <= bidx + SYM_W'(1);
        bld_addr <= bidx;
      end
      S_BUILD_END: begin
        cum_low     <= '0;
        cum_high    <= '0;
        total_count <= acc_sat;
        symbol_out  <= '0;
        status      <= 1'b0;
      end
      S_PROBE: begin
        mid <= mid_c;
        if (!search_more) begin
          symo <= lo[SYM_W-1:0];
        end
      end
      S_CMP: begin
        priority if (key < cum_a) begin
          hi <= {1'b0, mid};
        end else if (key > cum_a) begin
          lo <= {1'b0, mid};
        end else begin
          symo <= mid;
        end
      end
      S_FETCH: begin
        low_zero <= (symo == '0);
      end
      S_RESULT: begin
        cum_low     <= low_zero ? '0 : cum_a;
        cum_high    <= cum_b;
        total_count <= model_total;
        symbol_out  <= symo;
        status      <= st;
      end
      default: begin
      end
    endcase
  end

  // Checks on the command sequencing and the search
  `ASSERT_IMPLIES(a_done_idle, clk, rst, done, !busy, "result shown while busy")
  `ASSERT_NEXT(a_start_reacts, clk, rst, start && !busy, done || busy, "command lost")
  `ASSERT_IMPLIES(a_mid_inside, clk, rst, state == S_CMP, (lo < {1'b0, mid}) && ({1'b0, mid} < hi), "probe outside search range")
  `ASSERT_IMPLIES(a_err_last, clk, rst, done && status, symbol_out == SYM_LAST, "error without last symbol")

endmodule

`default_nettype wire
